// File: sv/skht_pkg.sv
// shared types and constants for the string key hash table
package skht_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_HASH_KIND  = 1'b1;

  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [11:0] insert_id;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] found_id;
    logic [12:0] slot_pos;
    logic [31:0] key_hash;
  } result_t;

  function automatic logic [31:0] hash_init(input logic kind);
    return kind ? FNV_BASIS : CRC_INIT;
  endfunction

endpackage

// File: sv/skht_hash.sv
// one-byte step of the crc32c or fnv-1a hash
module skht_hash import skht_pkg::*; (
  input  logic        kind,
  input  logic [31:0] hash_in,
  input  logic [7:0]  data,
  output logic [31:0] hash_out
);

  logic [31:0] mixed;
  logic [31:0] crc;

  always_comb begin
    mixed = hash_in ^ {24'd0, data};
    crc = mixed;
    for (int i = 0; i < 8; i++) begin
      crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
    end
    hash_out = kind ? 32'(mixed * FNV_PRIME) : crc;
  end

endmodule

// File: sv/string_key_hash_table.sv
// string key hash table top level: key hashing, slot probing and key compare
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_stall        item_t (one key byte or a clear)
//  result    out        result_valid / result_stall    result_t (one per finished key)
//  cfg       in         cfg_wen                        cfg_index, cfg_data
//
// key bytes are taken while the sequencer is idle; a finished key walks the slots,
// S_RD and S_HCHK per slot visited plus, on a lookup hash hit, S_LWAIT and S_LCHK for
// the length check and again per matching key byte, or S_COPY per stored byte on insert;
// all of it runs through slot and key memories with registered reads; after reset and
// after a clear all MAX_SLOTS slot hashes are swept to zero while no item is taken (cfg writes still land)
// a finished result sits in an output register; key bytes keep flowing while it
// waits, a last byte is held off until it is taken
module string_key_hash_table import skht_pkg::*; #(
  parameter int MAX_SLOTS     = 8192,
  parameter int MAX_TOKENS    = 4096,
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_wen,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LOG_MAX = $clog2(MAX_SLOTS + 1) - 1;
  localparam int TOK_W   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int KB_W    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LEN_W   = $clog2(MAX_KEY_BYTES + 1);
  localparam int BYTES   = MAX_TOKENS * MAX_KEY_BYTES;
  localparam int BA_W    = (BYTES > 1) ? $clog2(BYTES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_HCHK  = 3'd3;
  localparam logic [2:0] S_LWAIT = 3'd4;
  localparam logic [2:0] S_LCHK  = 3'd5;
  localparam logic [2:0] S_COPY  = 3'd6;

  logic [2:0] state;

  // configuration
  logic [3:0] size_log2;
  logic       hash_kind;

  // key being collected
  logic [31:0] running_hash;
  logic [LEN_W-1:0] key_length;
  logic        key_too_long;
  logic [7:0]  key_buf [MAX_KEY_BYTES];

  // probe walk
  logic [31:0]      h_fin;
  logic [IDX_W-1:0] probe_idx;
  logic [IDX_W-1:0] probe_cnt;
  logic [IDX_W-1:0] mask;
  logic             is_insert;
  logic [11:0]      cur_id;
  logic [TOK_W-1:0] tok;
  logic [BA_W-1:0]  byte_addr;
  logic [LEN_W-1:0] cmp_cnt;
  logic [IDX_W-1:0] clr_idx;

  // memories and their registered read data
  logic [31:0]      slot_hash_mem [MAX_SLOTS];
  logic [11:0]      slot_id_mem [MAX_SLOTS];
  logic [LEN_W-1:0] len_mem [MAX_TOKENS];
  logic [7:0]       byte_mem [BYTES];
  logic [31:0]      rd_hash;
  logic [11:0]      rd_id;
  logic [LEN_W-1:0] rd_len;
  logic [7:0]       rd_byte;

  logic [31:0] hash_step;
  logic [31:0] fin_raw;
  logic [31:0] fin_nz;
  logic        accept;
  logic        slot_we;
  logic [IDX_W-1:0] slot_wa;
  logic [3:0]  act_log2;

  skht_hash u_hash (
    .kind     (hash_kind),
    .hash_in  (running_hash),
    .data     (item.key_byte),
    .hash_out (hash_step)
  );

  // table size clamped to at least 2 and to what the slot store holds
  always_comb begin
    if (size_log2 < 4'd2) begin
      act_log2 = 4'd2;
    end else if (32'(size_log2) > LOG_MAX) begin
      act_log2 = 4'(LOG_MAX);
    end else begin
      act_log2 = size_log2;
    end
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (i < int'(act_log2));
    end
  end

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE) || (result_valid && item.last_byte);
  assign fin_raw    = item.byte_valid ? hash_step : running_hash;
  assign fin_nz     = (fin_raw == 32'd0) ? 32'd1 : fin_raw;

  // slot hash write port: clearing sweep or an insert claiming an empty slot
  assign slot_we = (state == S_CLR) ||
                   (state == S_HCHK && is_insert && rd_hash == 32'd0);
  assign slot_wa = (state == S_CLR) ? clr_idx : probe_idx;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_hash_mem[slot_wa] <= (state == S_CLR) ? 32'd0 : h_fin;
    end
    rd_hash <= slot_hash_mem[probe_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_HCHK && is_insert && rd_hash == 32'd0) begin
      slot_id_mem[probe_idx] <= cur_id;
    end
    rd_id <= slot_id_mem[probe_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_HCHK && is_insert && rd_hash == 32'd0) begin
      len_mem[tok] <= key_length;
    end
    rd_len <= len_mem[tok];
  end

  always_ff @(posedge clk) begin
    if (state == S_COPY) begin
      byte_mem[byte_addr] <= key_buf[cmp_cnt[KB_W-1:0]];
    end
    rd_byte <= byte_mem[byte_addr];
  end

  // key buffer fill
  always_ff @(posedge clk) begin
    if (accept && item.mode != MODE_CLEAR && item.mode != MODE_UNUSED && item.byte_valid &&
        32'(key_length) < MAX_KEY_BYTES) begin
      key_buf[key_length[KB_W-1:0]] <= item.key_byte;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      size_log2    <= 4'd13;
      hash_kind    <= 1'b0;
      running_hash <= CRC_INIT;
      key_length   <= '0;
      key_too_long <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (cfg_wen) begin
        case (cfg_index)
          CFG_TABLE_SIZE: size_log2 <= cfg_data;
          CFG_HASH_KIND: begin
            hash_kind <= cfg_data[0];
            if (key_length == '0 && !key_too_long) begin
              running_hash <= hash_init(cfg_data[0]);
            end
          end
          default: ;
        endcase
      end

      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == MAX_SLOTS - 1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            case (item.mode)
              MODE_CLEAR: begin
                running_hash <= hash_init(hash_kind);
                key_length   <= '0;
                key_too_long <= 1'b0;
                clr_idx      <= '0;
                state        <= S_CLR;
              end
              MODE_INSERT, MODE_LOOKUP: begin
                if (item.last_byte) begin
                  h_fin     <= fin_nz;
                  probe_idx <= fin_nz[IDX_W-1:0] & mask;
                  probe_cnt <= '0;
                  is_insert <= (item.mode == MODE_INSERT);
                  cur_id    <= item.insert_id;
                  tok       <= TOK_W'(item.insert_id % MAX_TOKENS);
                  if (key_too_long ||
                      (item.byte_valid && 32'(key_length) >= MAX_KEY_BYTES)) begin
                    result_valid        <= 1'b1;
                    result.status       <= ST_TOO_LONG;
                    result.found_id     <= '0;
                    result.slot_pos     <= '0;
                    result.key_hash     <= fin_nz;
                    running_hash        <= hash_init(hash_kind);
                    key_length          <= '0;
                    key_too_long        <= 1'b0;
                  end else begin
                    // final byte still fits the buffer
                    if (item.byte_valid) begin
                      running_hash <= hash_step;
                      key_length   <= key_length + 1'b1;
                    end
                    state <= S_RD;
                  end
                end else if (item.byte_valid) begin
                  running_hash <= hash_step;
                  if (32'(key_length) < MAX_KEY_BYTES) begin
                    key_length <= key_length + 1'b1;
                  end else begin
                    key_too_long <= 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_RD: state <= S_HCHK;

        S_HCHK: begin
          if (rd_hash == 32'd0) begin
            if (is_insert) begin
              byte_addr <= BA_W'(BA_W'(tok) * BA_W'(MAX_KEY_BYTES));
              cmp_cnt   <= '0;
              if (key_length == '0) begin
                result_valid      <= 1'b1;
                result.status     <= ST_INSERTED;
                result.found_id   <= '0;
                result.slot_pos   <= 13'(probe_idx);
                result.key_hash   <= h_fin;
                state             <= S_IDLE;
                running_hash      <= hash_init(hash_kind);
                key_length        <= '0;
              end else begin
                state <= S_COPY;
              end
            end else begin
              result_valid      <= 1'b1;
              result.status     <= ST_NOT_FOUND;
              result.found_id   <= '0;
              result.slot_pos   <= '0;
              result.key_hash   <= h_fin;
              state             <= S_IDLE;
              running_hash      <= hash_init(hash_kind);
              key_length        <= '0;
            end
          end else if (!is_insert && rd_hash == h_fin) begin
            // hash hit: compare the stored key of this slot's id
            tok       <= TOK_W'(rd_id % MAX_TOKENS);
            byte_addr <= BA_W'(BA_W'(TOK_W'(rd_id % MAX_TOKENS)) * BA_W'(MAX_KEY_BYTES));
            cmp_cnt   <= '0;
            state     <= S_LWAIT;
          end else if (probe_cnt == mask) begin
            result_valid      <= 1'b1;
            result.status     <= ST_FULL;
            result.found_id   <= '0;
            result.slot_pos   <= '0;
            result.key_hash   <= h_fin;
            state             <= S_IDLE;
            running_hash      <= hash_init(hash_kind);
            key_length        <= '0;
          end else begin
            probe_idx <= (probe_idx + 1'b1) & mask;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= S_RD;
          end
        end

        S_LWAIT: state <= S_LCHK;

        S_LCHK: begin
          if (rd_len == key_length && cmp_cnt == key_length) begin
            result_valid      <= 1'b1;
            result.status     <= ST_FOUND;
            result.found_id   <= rd_id;
            result.slot_pos   <= 13'(probe_idx);
            result.key_hash   <= h_fin;
            state             <= S_IDLE;
            running_hash      <= hash_init(hash_kind);
            key_length        <= '0;
          end else if (rd_len == key_length && rd_byte == key_buf[cmp_cnt[KB_W-1:0]]) begin
            cmp_cnt   <= cmp_cnt + 1'b1;
            byte_addr <= byte_addr + 1'b1;
            state     <= S_LWAIT;
          end else if (probe_cnt == mask) begin
            // mismatch after every slot of the table has been probed
            result_valid      <= 1'b1;
            result.status     <= ST_FULL;
            result.found_id   <= '0;
            result.slot_pos   <= '0;
            result.key_hash   <= h_fin;
            state             <= S_IDLE;
            running_hash      <= hash_init(hash_kind);
            key_length        <= '0;
          end else begin
            probe_idx <= (probe_idx + 1'b1) & mask;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= S_RD;
          end
        end

        S_COPY: begin
          cmp_cnt   <= cmp_cnt + 1'b1;
          byte_addr <= byte_addr + 1'b1;
          if (cmp_cnt + 1'b1 == key_length) begin
            result_valid      <= 1'b1;
            result.status     <= ST_INSERTED;
            result.found_id   <= '0;
            result.slot_pos   <= 13'(probe_idx);
            result.key_hash   <= h_fin;
            state             <= S_IDLE;
            running_hash      <= hash_init(hash_kind);
            key_length        <= '0;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // busy sequencer never takes an item
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> item_stall)
    else $error("item taken while sequencer busy");

  // a fresh result always carries a nonzero hash
  a_hash_nz: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> result.key_hash != 32'd0)
    else $error("zero key hash in result");

  // only a found result names an id
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_FOUND |-> result.found_id == 12'd0)
    else $error("found_id set without a match");

endmodule
